@@ rtl/core/oams_pkg.sv @@
// Package for the obstacle-avoid motion sequencer.
// Holds phase, motion, command and register index codes and the register set type.
// No dependencies.
package oams_pkg;

  localparam int TimeBitsDefault = 32;
  localparam int TsW             = 32;
  localparam int CfgW            = 16;
  localparam int CfgIdxW         = 3;

  typedef enum logic [3:0] {
    PH_STOP    = 4'd0,
    PH_FORWARD = 4'd1,
    PH_BRAKE   = 4'd2,
    PH_REVERSE = 4'd3,
    PH_PAUSE   = 4'd4,
    PH_LEFT    = 4'd5,
    PH_RIGHT   = 4'd6,
    PH_PROBE   = 4'd7,
    PH_VERIFY  = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    MOT_STOP    = 3'd0,
    MOT_FORWARD = 3'd1,
    MOT_BRAKE   = 3'd2,
    MOT_REVERSE = 3'd3,
    MOT_LEFT    = 3'd4,
    MOT_RIGHT   = 3'd5,
    MOT_PROBE   = 3'd6
  } motion_t;

  localparam logic [2:0] CMD_STOP    = 3'd1;
  localparam logic [2:0] CMD_FORWARD = 3'd2;
  localparam logic [2:0] CMD_LEFT    = 3'd3;
  localparam logic [2:0] CMD_RIGHT   = 3'd4;

  localparam logic [CfgIdxW-1:0] REG_BRAKE   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_REVERSE = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PAUSE   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TURN    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_PROBE   = 3'd4;

  localparam logic [CfgW-1:0] BRAKE_RST   = 16'd300;
  localparam logic [CfgW-1:0] REVERSE_RST = 16'd500;
  localparam logic [CfgW-1:0] PAUSE_RST   = 16'd200;
  localparam logic [CfgW-1:0] TURN_RST    = 16'd400;
  localparam logic [CfgW-1:0] PROBE_RST   = 16'd300;

  typedef struct packed {
    logic [CfgW-1:0] brake_ms;
    logic [CfgW-1:0] reverse_ms;
    logic [CfgW-1:0] pause_ms;
    logic [CfgW-1:0] turn_ms;
    logic [CfgW-1:0] probe_ms;
  } cfg_t;

  function automatic motion_t motion_of(input phase_t ph);
    motion_t m;
    case (ph)
      PH_FORWARD: m = MOT_FORWARD;
      PH_BRAKE:   m = MOT_BRAKE;
      PH_PAUSE:   m = MOT_BRAKE;
      PH_VERIFY:  m = MOT_BRAKE;
      PH_REVERSE: m = MOT_REVERSE;
      PH_LEFT:    m = MOT_LEFT;
      PH_RIGHT:   m = MOT_RIGHT;
      PH_PROBE:   m = MOT_PROBE;
      default:    m = MOT_STOP;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/core/oams_cfg.sv @@
// Duration register file of the obstacle-avoid motion sequencer.
// Depends on oams_pkg.
module oams_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [oams_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [oams_pkg::CfgW-1:0]     cfg_wdata,
  output oams_pkg::cfg_t                cfg
);

  oams_pkg::cfg_t cfg_r;
  oams_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        oams_pkg::REG_BRAKE:   cfg_nxt.brake_ms   = cfg_wdata;
        oams_pkg::REG_REVERSE: cfg_nxt.reverse_ms = cfg_wdata;
        oams_pkg::REG_PAUSE:   cfg_nxt.pause_ms   = cfg_wdata;
        oams_pkg::REG_TURN:    cfg_nxt.turn_ms    = cfg_wdata;
        oams_pkg::REG_PROBE:   cfg_nxt.probe_ms   = cfg_wdata;
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brake_ms   <= oams_pkg::BRAKE_RST;
      cfg_r.reverse_ms <= oams_pkg::REVERSE_RST;
      cfg_r.pause_ms   <= oams_pkg::PAUSE_RST;
      cfg_r.turn_ms    <= oams_pkg::TURN_RST;
      cfg_r.probe_ms   <= oams_pkg::PROBE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/oams_core.sv @@
// Phase state and transition logic of the obstacle-avoid motion sequencer.
// Depends on oams_pkg.
module oams_core #(
  parameter int TIME_BITS = oams_pkg::TimeBitsDefault
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [2:0]                 cmd,
  input  logic [oams_pkg::TsW-1:0]   ts,
  input  oams_pkg::cfg_t             cfg,
  output oams_pkg::phase_t           res_phase,
  output oams_pkg::motion_t          res_motion
);

  function automatic logic [TIME_BITS-1:0] widen(input logic [oams_pkg::CfgW-1:0] v);
    logic [TIME_BITS+oams_pkg::CfgW-1:0] t;
    t = {{TIME_BITS{1'b0}}, v};
    return t[TIME_BITS-1:0];
  endfunction

  oams_pkg::phase_t      phase_r, phase_nxt;
  logic [TIME_BITS-1:0]  start_r, start_nxt;
  logic                  right_r, right_nxt;

  logic [TIME_BITS+oams_pkg::TsW-1:0] ts_ext;
  logic [TIME_BITS-1:0]  now;
  logic [TIME_BITS-1:0]  elapsed;
  logic [TIME_BITS-1:0]  limit;
  logic                  expired;
  logic                  turn;

  assign ts_ext  = {{TIME_BITS{1'b0}}, ts};
  assign now     = ts_ext[TIME_BITS-1:0];
  assign elapsed = now - start_r;
  assign turn    = (cmd == oams_pkg::CMD_LEFT) || (cmd == oams_pkg::CMD_RIGHT);

  always_comb begin
    case (phase_r)
      oams_pkg::PH_BRAKE:   limit = widen(cfg.brake_ms);
      oams_pkg::PH_REVERSE: limit = widen(cfg.reverse_ms);
      oams_pkg::PH_PAUSE:   limit = widen(cfg.pause_ms);
      oams_pkg::PH_LEFT:    limit = widen(cfg.turn_ms);
      oams_pkg::PH_RIGHT:   limit = widen(cfg.turn_ms);
      oams_pkg::PH_PROBE:   limit = widen(cfg.probe_ms);
      default:              limit = '0;
    endcase
  end

  assign expired = (elapsed >= limit);

  always_comb begin
    phase_nxt = phase_r;
    start_nxt = start_r;
    right_nxt = right_r;
    if (cmd == oams_pkg::CMD_STOP) begin
      if (phase_r != oams_pkg::PH_STOP) begin
        phase_nxt = oams_pkg::PH_STOP;
        start_nxt = now;
      end
    end else begin
      case (phase_r)
        oams_pkg::PH_STOP: begin
          if (cmd == oams_pkg::CMD_FORWARD) begin
            phase_nxt = oams_pkg::PH_FORWARD;
            start_nxt = now;
          end else if (turn) begin
            right_nxt = (cmd == oams_pkg::CMD_RIGHT);
            phase_nxt = oams_pkg::PH_REVERSE;
            start_nxt = now;
          end
        end
        oams_pkg::PH_FORWARD: begin
          if (turn) begin
            right_nxt = (cmd == oams_pkg::CMD_RIGHT);
            phase_nxt = oams_pkg::PH_BRAKE;
            start_nxt = now;
          end
        end
        oams_pkg::PH_BRAKE: begin
          if (expired) begin
            phase_nxt = oams_pkg::PH_REVERSE;
            start_nxt = now;
          end
        end
        oams_pkg::PH_REVERSE: begin
          if (expired) begin
            phase_nxt = oams_pkg::PH_PAUSE;
            start_nxt = now;
          end
        end
        oams_pkg::PH_PAUSE: begin
          if (expired) begin
            phase_nxt = right_r ? oams_pkg::PH_RIGHT : oams_pkg::PH_LEFT;
            start_nxt = now;
          end
        end
        oams_pkg::PH_LEFT, oams_pkg::PH_RIGHT: begin
          if (expired) begin
            phase_nxt = oams_pkg::PH_PROBE;
            start_nxt = now;
          end
        end
        oams_pkg::PH_PROBE: begin
          if (expired) begin
            phase_nxt = (cmd == oams_pkg::CMD_FORWARD) ? oams_pkg::PH_FORWARD
                                                       : oams_pkg::PH_VERIFY;
            start_nxt = now;
          end
        end
        oams_pkg::PH_VERIFY: begin
          if (cmd == oams_pkg::CMD_FORWARD) begin
            phase_nxt = oams_pkg::PH_FORWARD;
            start_nxt = now;
          end
        end
        default: begin
          phase_nxt = oams_pkg::PH_STOP;
          start_nxt = now;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= oams_pkg::PH_STOP;
      start_r <= '0;
      right_r <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      start_r <= start_nxt;
      right_r <= right_nxt;
    end
  end

  assign res_phase  = phase_nxt;
  assign res_motion = oams_pkg::motion_of(phase_nxt);

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r) && $stable(start_r) && $stable(right_r))
    else $error("sequencer state changed without a word");

  a_stop_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (step && cmd == oams_pkg::CMD_STOP) |=> phase_r == oams_pkg::PH_STOP)
    else $error("stop command did not reach stop phase");

  a_turn_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == oams_pkg::PH_FORWARD && cmd == oams_pkg::CMD_RIGHT)
      |=> right_r && phase_r == oams_pkg::PH_BRAKE)
    else $error("right turn not latched on brake entry");

endmodule

@@ rtl/core/obstacle_avoid_motion_sequencer_top.sv @@
// Top level of the obstacle-avoid motion sequencer: input and result registers.
// Depends on oams_pkg, oams_cfg and oams_core.
// An accepted word waits in the input register until its result is registered.
// Throughput: one word per cycle unless the output stalls; a word held in the result
// register blocks the next word only while the input register is also full.
// Reset: synchronous active-low; phase returns to stop, start time and turn direction
// clear, duration registers reload their defaults.
module obstacle_avoid_motion_sequencer_top #(
  parameter int TIME_BITS = oams_pkg::TimeBitsDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_command,
  input  logic [oams_pkg::TsW-1:0]      in_timestamp_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    out_motion,
  output logic [3:0]                    out_phase,
  input  logic                          cfg_we,
  input  logic [oams_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [oams_pkg::CfgW-1:0]     cfg_wdata
);

  oams_pkg::cfg_t           cfg;
  oams_pkg::phase_t         res_phase;
  oams_pkg::motion_t        res_motion;

  logic                     in_v_r;
  logic [2:0]               cmd_r;
  logic [oams_pkg::TsW-1:0] ts_r;
  logic                     out_v_r;
  oams_pkg::phase_t         phase_r;
  oams_pkg::motion_t        motion_r;
  logic                     advance;
  logic                     step;

  assign advance  = !out_v_r || out_ready;
  assign step     = in_v_r && advance;
  assign in_ready = !in_v_r || advance;

  oams_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  oams_core #(.TIME_BITS(TIME_BITS)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .cmd        (cmd_r),
    .ts         (ts_r),
    .cfg        (cfg),
    .res_phase  (res_phase),
    .res_motion (res_motion)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (advance) begin
        out_v_r <= in_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_command;
      ts_r  <= in_timestamp_ms;
    end
    if (step) begin
      phase_r  <= res_phase;
      motion_r <= res_motion;
    end
  end

  assign out_valid  = out_v_r;
  assign out_phase  = phase_r;
  assign out_motion = motion_r;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (in_v_r && out_v_r && !out_ready))
    else $error("input stalled without a blocked result word");

  a_forward_motion: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && phase_r == oams_pkg::PH_FORWARD) |-> motion_r == oams_pkg::MOT_FORWARD)
    else $error("forward phase reported with wrong motion");

  a_word_moves: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_v_r)
    else $error("word left the input register but no result word appeared");

endmodule
